// ===== hdl/mwo_pkg.sv =====
// Shared types, widths and the microcode ROM of the mecanum wheel odometry unit.
// Depends on nothing; imported by every module of the block.
package mwo_pkg;

   // field and datapath widths
   localparam int CNT_W    = 16;               // raw encoder count
   localparam int TICK_W   = CNT_W + 1;        // sign-corrected count
   localparam int DIFF_W   = TICK_W + 1;       // count difference
   localparam int SUM_W    = DIFF_W + 2;       // mixed sum of four differences
   localparam int DPC_W    = 24;
   localparam int TG_W     = 16;
   localparam int EUS_W    = 24;
   localparam int OUT_W    = 32;
   localparam int MUL_A_W  = 36;
   localparam int MUL_B_W  = 25;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int STEP_W   = 35;
   localparam int DVD_W    = 56;
   localparam int QUO_W    = 32;
   localparam int ROUND_XY = 10;
   localparam int ROUND_T  = 24;
   localparam int T_SPLIT  = 20;
   localparam int TD_TOP   = SUM_W + DPC_W - 1;
   localparam int US_PER_SECOND = 1000000;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_PER_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN      = CSR_IDX_W'(1);
   localparam logic [DPC_W-1:0] DPC_RESET = DPC_W'(39845);
   localparam logic [TG_W-1:0]  TG_RESET  = TG_W'(33640);

   // sequencer
   localparam int PC_W  = 4;
   localparam int LCNT_W = $clog2(QUO_W);
   localparam logic [LCNT_W-1:0] DIV_LAST = LCNT_W'(QUO_W - 1);

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [3:0] {
      OP_ACCEPT, OP_MUL_X, OP_MUL_Y, OP_MUL_TD, OP_MUL_THI, OP_MUL_TLO,
      OP_SUM_T, OP_MUL_VX, OP_LD_VX, OP_LD_VY, OP_LD_VT, OP_DIV, OP_OUT
   } op_type;

   typedef enum logic [1:0] {HOLD_NONE, HOLD_REQ, HOLD_OUT} hold_type;
   typedef enum logic [1:0] {JMP_NONE, JMP_ALWAYS, JMP_LOOP} jmp_type;

   typedef struct packed {
      op_type   op;
      hold_type hold;
      jmp_type  jmp;
      logic     cnt_load;
      pc_type   target;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   fire;
      logic   take_ok;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic req_valid;
      logic out_free;
   } stat_type;

   localparam pc_type STEP_ACCEPT = PC_W'(0);
   localparam pc_type STEP_DIV    = PC_W'(11);

   function automatic ucode_type mk(op_type op, hold_type hold, jmp_type jmp,
                                    logic cnt_load, pc_type target);
      ucode_type w;
      w.op       = op;
      w.hold     = hold;
      w.jmp      = jmp;
      w.cnt_load = cnt_load;
      w.target   = target;
      return w;
   endfunction

   // microcode program: one control word per step
   function automatic ucode_type ucode_rom(pc_type pc);
      ucode_type w;
      case (pc)
         4'd0:    w = mk(OP_ACCEPT,  HOLD_REQ,  JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd1:    w = mk(OP_MUL_X,   HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd2:    w = mk(OP_MUL_Y,   HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd3:    w = mk(OP_MUL_TD,  HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd4:    w = mk(OP_MUL_THI, HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd5:    w = mk(OP_MUL_TLO, HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd6:    w = mk(OP_SUM_T,   HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd7:    w = mk(OP_MUL_VX,  HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd8:    w = mk(OP_LD_VX,   HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd9:    w = mk(OP_LD_VY,   HOLD_NONE, JMP_NONE,   1'b0, STEP_ACCEPT);
         4'd10:   w = mk(OP_LD_VT,   HOLD_NONE, JMP_NONE,   1'b1, STEP_ACCEPT);
         4'd11:   w = mk(OP_DIV,     HOLD_NONE, JMP_LOOP,   1'b0, STEP_DIV);
         4'd12:   w = mk(OP_OUT,     HOLD_OUT,  JMP_ALWAYS, 1'b0, STEP_ACCEPT);
         default: w = mk(OP_ACCEPT,  HOLD_NONE, JMP_ALWAYS, 1'b0, STEP_ACCEPT);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/mwo_seq.sv =====
// Microcode sequencer: step counter, loop counter and control ROM lookup.
// Depends on mwo_pkg for the control word layout and the program.
module mwo_seq import mwo_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctl_type  ctl
);

   pc_type            pc_ff, pc_in;
   logic [LCNT_W-1:0] cnt_ff, cnt_in;
   ucode_type         cw;
   logic              stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= STEP_ACCEPT;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   // next step: hold while waiting on a handshake, else branch or fall through
   always_comb begin
      cw     = ucode_rom(pc_ff);
      stall  = ((cw.hold == HOLD_REQ) && !stat.req_valid) ||
               ((cw.hold == HOLD_OUT) && !stat.out_free);
      pc_in  = pc_ff;
      cnt_in = cnt_ff;
      if (!stall) begin
         case (cw.jmp)
            JMP_ALWAYS: pc_in = cw.target;
            JMP_LOOP: begin
               if (cnt_ff != '0) begin
                  pc_in  = cw.target;
                  cnt_in = cnt_ff - LCNT_W'(1);
               end else begin
                  pc_in = pc_ff + PC_W'(1);
               end
            end
            default: pc_in = pc_ff + PC_W'(1);
         endcase
         if (cw.cnt_load) begin
            cnt_in = DIV_LAST;
         end
      end
      ctl.op      = cw.op;
      ctl.fire    = !stall;
      ctl.take_ok = (cw.hold == HOLD_REQ);
   end

endmodule

// ===== hdl/mwo_div_lane.sv =====
// One velocity lane: rounded restoring division of |step*1e6| by elapsed time,
// one quotient bit per cycle while shift is asserted, then sign and saturation. Depends on mwo_pkg.
module mwo_div_lane import mwo_pkg::*; (
   input  logic                     clock,
   input  logic                     load,
   input  logic                     shift,
   input  logic signed [PROD_W-1:0] num,
   input  logic [EUS_W-1:0]         divisor,
   output logic signed [OUT_W-1:0]  vel
);

   logic              neg_ff, neg_in;
   logic              big_ff, big_in;
   logic [EUS_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [PROD_W-1:0] mag;
   logic [DVD_W-1:0]  dvd;
   logic [EUS_W:0]    trial;
   logic              qbit;

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      big_ff <= big_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      neg_in = neg_ff;
      big_in = big_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      // magnitude plus half the divisor gives round half away from zero
      mag   = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
      dvd   = mag[DVD_W-1:0] + DVD_W'(divisor >> 1);
      trial = {rem_ff, quo_ff[QUO_W-1]};
      qbit  = (trial >= {1'b0, divisor});
      if (load) begin
         neg_in = num[PROD_W-1];
         big_in = (dvd[DVD_W-1:QUO_W] >= divisor);  // quotient needs 33+ bits
         rem_in = dvd[DVD_W-1:QUO_W];
         quo_in = dvd[QUO_W-1:0];
      end else if (shift) begin
         rem_in = qbit ? EUS_W'(trial - {1'b0, divisor}) : trial[EUS_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], qbit};
      end
   end

   // zero time gives zero; otherwise apply sign and clamp
   always_comb begin
      if (divisor == '0) begin
         vel = '0;
      end else if (neg_ff) begin
         vel = (big_ff || quo_ff[QUO_W-1]) ? {1'b1, {(OUT_W-1){1'b0}}}
                                           : OUT_W'(-$signed(quo_ff));
      end else begin
         vel = (big_ff || quo_ff[QUO_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}}
                                           : $signed(quo_ff);
      end
   end

endmodule

// ===== hdl/mwo_datapath.sv =====
// Datapath: wheel mixing, shared multiplier, rounding, accumulators,
// three division lanes and the result register. Depends on mwo_pkg, mwo_div_lane.
module mwo_datapath import mwo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  ctl_type                 ctl,
   output stat_type                stat,
   input  logic [DPC_W-1:0]        dist_per_count,
   input  logic [TG_W-1:0]         turn_gain,
   input  logic                    req_valid,
   input  logic signed [CNT_W-1:0] req_raw_count_0,
   input  logic signed [CNT_W-1:0] req_raw_count_1,
   input  logic signed [CNT_W-1:0] req_raw_count_2,
   input  logic signed [CNT_W-1:0] req_raw_count_3,
   input  logic [EUS_W-1:0]        req_elapsed_us,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_pos_x,
   output logic signed [OUT_W-1:0] rsp_pos_y,
   output logic signed [OUT_W-1:0] rsp_heading,
   output logic signed [OUT_W-1:0] rsp_vel_x,
   output logic signed [OUT_W-1:0] rsp_vel_y,
   output logic signed [OUT_W-1:0] rsp_vel_turn
);

   localparam logic signed [PROD_W-1:0] HALF_XY = PROD_W'(1) << (ROUND_XY - 1);
   localparam logic signed [PROD_W-1:0] HALF_T  = PROD_W'(1) << (ROUND_T - 1);
   localparam logic signed [MUL_B_W-1:0] US_B   = MUL_B_W'(US_PER_SECOND);

   // tick order: front-left, front-right, back-left, back-right
   logic signed [TICK_W-1:0] last_ff [4];
   logic signed [TICK_W-1:0] tick [4];
   logic signed [DIFF_W-1:0] d [4];
   logic signed [SUM_W-1:0]  sx_ff, sy_ff, st_ff;
   logic [EUS_W-1:0]         e_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in, tmp_ff, tmp_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [STEP_W-1:0] step_x_ff, step_y_ff, step_t_ff;
   logic signed [PROD_W-1:0] sum_xy, sum_t;
   logic [OUT_W-1:0]         acc_x_ff, acc_y_ff, acc_h_ff;
   logic signed [OUT_W-1:0]  vel_x, vel_y, vel_t;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  pos_x_ff, pos_y_ff, head_ff, vx_ff, vy_ff, vt_ff;
   logic                     take, out_go, div_go;

   assign take   = ctl.fire && (ctl.op == OP_ACCEPT) && req_valid;
   assign out_go = ctl.fire && (ctl.op == OP_OUT);
   assign div_go = ctl.fire && (ctl.op == OP_DIV);

   always_comb begin
      stat.req_valid = req_valid;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // sign correction and mecanum mixing of count differences
   always_comb begin
      tick[0] = TICK_W'(req_raw_count_2);
      tick[1] = -TICK_W'(req_raw_count_1);
      tick[2] = TICK_W'(req_raw_count_3);
      tick[3] = -TICK_W'(req_raw_count_0);
      for (int i = 0; i < 4; i++) begin
         d[i] = DIFF_W'(tick[i]) - DIFF_W'(last_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= '0;
         end
      end else if (take) begin
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= tick[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sx_ff <= SUM_W'(d[0]) + SUM_W'(d[1]) + SUM_W'(d[2]) + SUM_W'(d[3]);
         sy_ff <= -SUM_W'(d[0]) + SUM_W'(d[1]) + SUM_W'(d[2]) - SUM_W'(d[3]);
         st_ff <= -SUM_W'(d[0]) + SUM_W'(d[1]) - SUM_W'(d[2]) + SUM_W'(d[3]);
         e_ff  <= req_elapsed_us;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      tmp_in = tmp_ff;
      case (ctl.op)
         OP_MUL_X: begin
            mul_a = MUL_A_W'(sx_ff);
            mul_b = $signed({1'b0, dist_per_count});
         end
         OP_MUL_Y: begin
            mul_a = MUL_A_W'(sy_ff);
            mul_b = $signed({1'b0, dist_per_count});
         end
         OP_MUL_TD: begin
            mul_a = MUL_A_W'(st_ff);
            mul_b = $signed({1'b0, dist_per_count});
         end
         OP_MUL_THI: begin
            // high half of st*dpc times gain; keep the low half for next step
            mul_a  = MUL_A_W'($signed(prod_ff[TD_TOP:T_SPLIT]));
            mul_b  = MUL_B_W'($signed({1'b0, turn_gain}));
            tmp_in = PROD_W'($signed({1'b0, prod_ff[T_SPLIT-1:0]}));
         end
         OP_MUL_TLO: begin
            mul_a  = MUL_A_W'($signed({1'b0, tmp_ff[T_SPLIT-1:0]}));
            mul_b  = MUL_B_W'($signed({1'b0, turn_gain}));
            tmp_in = prod_ff <<< T_SPLIT;
         end
         OP_MUL_VX: begin
            mul_a = MUL_A_W'(step_x_ff);
            mul_b = US_B;
         end
         OP_LD_VX: begin
            mul_a = MUL_A_W'(step_y_ff);
            mul_b = US_B;
         end
         OP_LD_VY: begin
            mul_a = MUL_A_W'(step_t_ff);
            mul_b = US_B;
         end
         default: begin
            mul_a = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // rounding to nearest, ties upward
   assign sum_xy = prod_ff + HALF_XY;
   assign sum_t  = tmp_ff + prod_ff + HALF_T;

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         if (ctl.op inside {OP_MUL_X, OP_MUL_Y, OP_MUL_TD, OP_MUL_THI, OP_MUL_TLO,
                            OP_MUL_VX, OP_LD_VX, OP_LD_VY}) begin
            prod_ff <= prod_in;
         end
         tmp_ff <= tmp_in;
         if (ctl.op == OP_MUL_Y) begin
            step_x_ff <= sum_xy[ROUND_XY+STEP_W-1:ROUND_XY];
         end
         if (ctl.op == OP_MUL_TD) begin
            step_y_ff <= sum_xy[ROUND_XY+STEP_W-1:ROUND_XY];
         end
         if (ctl.op == OP_SUM_T) begin
            step_t_ff <= sum_t[ROUND_T+STEP_W-1:ROUND_T];
         end
      end
   end

   // wrapping accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_h_ff <= '0;
      end else if (ctl.fire && (ctl.op == OP_MUL_VX)) begin
         acc_x_ff <= acc_x_ff + step_x_ff[OUT_W-1:0];
         acc_y_ff <= acc_y_ff + step_y_ff[OUT_W-1:0];
         acc_h_ff <= acc_h_ff + step_t_ff[OUT_W-1:0];
      end
   end

   mwo_div_lane u_lane_x (
      .clock   (clock),
      .load    (ctl.fire && (ctl.op == OP_LD_VX)),
      .shift   (div_go),
      .num     (prod_ff),
      .divisor (e_ff),
      .vel     (vel_x)
   );

   mwo_div_lane u_lane_y (
      .clock   (clock),
      .load    (ctl.fire && (ctl.op == OP_LD_VY)),
      .shift   (div_go),
      .num     (prod_ff),
      .divisor (e_ff),
      .vel     (vel_y)
   );

   mwo_div_lane u_lane_t (
      .clock   (clock),
      .load    (ctl.fire && (ctl.op == OP_LD_VT)),
      .shift   (div_go),
      .num     (prod_ff),
      .divisor (e_ff),
      .vel     (vel_t)
   );

   // result register: one beat held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_go) begin
         pos_x_ff <= $signed(acc_x_ff);
         pos_y_ff <= $signed(acc_y_ff);
         head_ff  <= $signed(acc_h_ff);
         vx_ff    <= vel_x;
         vy_ff    <= vel_y;
         vt_ff    <= vel_t;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x    = pos_x_ff;
   assign rsp_pos_y    = pos_y_ff;
   assign rsp_heading  = head_ff;
   assign rsp_vel_x    = vx_ff;
   assign rsp_vel_y    = vy_ff;
   assign rsp_vel_turn = vt_ff;

endmodule

// ===== hdl/mecanum_wheel_odometry_unit.sv =====
// Each accepted beat of four wheel counts and elapsed microseconds yields one result
// beat. The program runs the accept step, 10 steps of scaling and rounding around the
// shared 36x25 multiplier, one division step repeated for each of the 32 quotient bits
// of the three parallel bit-per-cycle velocity dividers, and one step to load the result
// register. Beats are taken only at the accept step, never while one is still in the
// program. The load step waits while the previous result still sits unread in the
// output register. Once it loads, the program returns to its first step, and a new beat
// can be taken while that result waits. Configuration writes are taken every cycle.
// Top level: holds the configuration registers and joins sequencer and datapath.
// Depends on mwo_pkg, mwo_seq, mwo_datapath.
module mecanum_wheel_odometry_unit import mwo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [CNT_W-1:0] req_raw_count_0,
   input  logic signed [CNT_W-1:0] req_raw_count_1,
   input  logic signed [CNT_W-1:0] req_raw_count_2,
   input  logic signed [CNT_W-1:0] req_raw_count_3,
   input  logic [EUS_W-1:0]        req_elapsed_us,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_pos_x,
   output logic signed [OUT_W-1:0] rsp_pos_y,
   output logic signed [OUT_W-1:0] rsp_heading,
   output logic signed [OUT_W-1:0] rsp_vel_x,
   output logic signed [OUT_W-1:0] rsp_vel_y,
   output logic signed [OUT_W-1:0] rsp_vel_turn,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [DPC_W-1:0]        csr_wdata
);

   logic [DPC_W-1:0] dpc_ff;
   logic [TG_W-1:0]  tg_ff;
   ctl_type          ctl;
   stat_type         stat;

   // configuration registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= DPC_RESET;
         tg_ff  <= TG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIST_PER_COUNT: dpc_ff <= csr_wdata;
            CSR_TURN_GAIN:      tg_ff  <= csr_wdata[TG_W-1:0];
            default:            dpc_ff <= dpc_ff;
         endcase
      end
   end

   assign req_ready = ctl.take_ok;

   mwo_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   mwo_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .dist_per_count  (dpc_ff),
      .turn_gain       (tg_ff),
      .req_valid       (req_valid),
      .req_raw_count_0 (req_raw_count_0),
      .req_raw_count_1 (req_raw_count_1),
      .req_raw_count_2 (req_raw_count_2),
      .req_raw_count_3 (req_raw_count_3),
      .req_elapsed_us  (req_elapsed_us),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_heading     (rsp_heading),
      .rsp_vel_x       (rsp_vel_x),
      .rsp_vel_y       (rsp_vel_y),
      .rsp_vel_turn    (rsp_vel_turn)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the mecanum wheel odometry unit.
// Needs mwo_pkg and mecanum_wheel_odometry_unit; an in-bench predictor checks every beat.
module tb;
   import mwo_pkg::*;

   localparam int IDLE_PCT      = 28;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 242;
   localparam int BURST_PHASE   = 5;
   localparam int DIRECTED_ROWS = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 60;

   // spare register slots, writes there must have no effect
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   localparam logic [EUS_W-1:0] EUS_MAX = '1;
   localparam logic [OUT_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] VEL_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [3:0][CNT_W-1:0] raw_count;
      logic [EUS_W-1:0]      elapsed_us;
   } wheel_beat_type;

   typedef struct packed {
      logic [OUT_W-1:0] pos_x;
      logic [OUT_W-1:0] pos_y;
      logic [OUT_W-1:0] heading;
      logic [OUT_W-1:0] vel_x;
      logic [OUT_W-1:0] vel_y;
      logic [OUT_W-1:0] vel_turn;
   } odometry_type;

   typedef struct {
      wheel_beat_type beat;
      bit             known;
      odometry_type   result;
   } table_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [CNT_W-1:0] req_raw_count_0 = '0;
   logic signed [CNT_W-1:0] req_raw_count_1 = '0;
   logic signed [CNT_W-1:0] req_raw_count_2 = '0;
   logic signed [CNT_W-1:0] req_raw_count_3 = '0;
   logic [EUS_W-1:0]        req_elapsed_us = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_pos_x;
   logic signed [OUT_W-1:0] rsp_pos_y;
   logic signed [OUT_W-1:0] rsp_heading;
   logic signed [OUT_W-1:0] rsp_vel_x;
   logic signed [OUT_W-1:0] rsp_vel_y;
   logic signed [OUT_W-1:0] rsp_vel_turn;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [DPC_W-1:0]        csr_wdata = '0;

   // predictor state: configuration, previous ticks, accumulators
   logic [DPC_W-1:0]         meters_per_count;
   logic [TG_W-1:0]          turn_gain_q;
   logic signed [TICK_W-1:0] prev_tick [4];
   logic [OUT_W-1:0]         pos_x_sum;
   logic [OUT_W-1:0]         pos_y_sum;
   logic [OUT_W-1:0]         heading_sum;

   odometry_type  pending_odometry [$];
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   bit            no_idle = 1'b0;
   table_row_type directed_rows [DIRECTED_ROWS];

   mecanum_wheel_odometry_unit DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // rate = round(step * 1e6 / elapsed), ties away from zero, saturated
   function automatic logic [OUT_W-1:0] scaled_rate(longint step, logic [EUS_W-1:0] e);
      longint          n;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned div;
      if (e == '0) return '0;
      n   = step * 64'sd1000000;
      mag = (n < 0) ? -n : n;
      div = e;
      q   = (mag + div / 2) / div;
      if (n < 0) return (q >= 64'h8000_0000) ? VEL_MIN : OUT_W'(-q);
      return (q > 64'h7FFF_FFFF) ? VEL_MAX : q[OUT_W-1:0];
   endfunction

   // one odometry update: mix count deltas, scale, round, accumulate
   task automatic advance_odometry(input wheel_beat_type b, output odometry_type r);
      longint tick [4];
      longint delta [4];
      longint dpc, gain, sx, sy, st, step_x, step_y, step_t;
      dpc     = meters_per_count;
      gain    = turn_gain_q;
      tick[0] = longint'($signed(b.raw_count[2]));    // front-left
      tick[1] = -longint'($signed(b.raw_count[1]));   // front-right, negated
      tick[2] = longint'($signed(b.raw_count[3]));    // back-left
      tick[3] = -longint'($signed(b.raw_count[0]));   // back-right, negated
      for (int i = 0; i < 4; i++) begin
         delta[i]     = tick[i] - longint'(prev_tick[i]);
         prev_tick[i] = tick[i][TICK_W-1:0];
      end
      sx = delta[0] + delta[1] + delta[2] + delta[3];
      sy = -delta[0] + delta[1] + delta[2] - delta[3];
      st = -delta[0] + delta[1] - delta[2] + delta[3];
      // round to nearest, ties up: arithmetic shift floors
      step_x = (sx * dpc + (64'sd1 <<< (ROUND_XY - 1))) >>> ROUND_XY;
      step_y = (sy * dpc + (64'sd1 <<< (ROUND_XY - 1))) >>> ROUND_XY;
      step_t = (st * dpc * gain + (64'sd1 <<< (ROUND_T - 1))) >>> ROUND_T;
      pos_x_sum   += step_x[OUT_W-1:0];
      pos_y_sum   += step_y[OUT_W-1:0];
      heading_sum += step_t[OUT_W-1:0];
      r.pos_x    = pos_x_sum;
      r.pos_y    = pos_y_sum;
      r.heading  = heading_sum;
      r.vel_x    = scaled_rate(step_x, b.elapsed_us);
      r.vel_y    = scaled_rate(step_y, b.elapsed_us);
      r.vel_turn = scaled_rate(step_t, b.elapsed_us);
   endtask

   function automatic table_row_type mk_row(logic [CNT_W-1:0] c0, logic [CNT_W-1:0] c1,
                                            logic [CNT_W-1:0] c2, logic [CNT_W-1:0] c3,
                                            logic [EUS_W-1:0] e, bit known);
      table_row_type row;
      row.beat.raw_count = {c3, c2, c1, c0};
      row.beat.elapsed_us = e;
      row.known  = known;
      row.result = '0;
      return row;
   endfunction

   // mostly plausible wheel motion, plus random, extreme and standstill beats
   function automatic wheel_beat_type next_beat(wheel_beat_type prev);
      wheel_beat_type b;
      int             kind;
      int             span;
      kind = $urandom_range(99);
      b    = prev;
      if (kind < 60) begin
         span = ($urandom_range(3) == 0) ? 2000 : 64;
         for (int i = 0; i < 4; i++)
            b.raw_count[i] = prev.raw_count[i] + CNT_W'($urandom_range(2 * span) - span);
         case ($urandom_range(9))
            0:       b.elapsed_us = EUS_MAX;
            1:       b.elapsed_us = EUS_W'($urandom);
            2:       b.elapsed_us = EUS_W'($urandom_range(16, 1));
            default: b.elapsed_us = EUS_W'($urandom_range(20000, 500));
         endcase
      end else if (kind < 75) begin
         for (int i = 0; i < 4; i++)
            b.raw_count[i] = CNT_W'($urandom);
         b.elapsed_us = EUS_W'($urandom);
      end else if (kind < 87) begin
         for (int i = 0; i < 4; i++)
            case ($urandom_range(3))
               0:       b.raw_count[i] = 16'h8000;
               1:       b.raw_count[i] = 16'h7FFF;
               2:       b.raw_count[i] = 16'h0000;
               default: b.raw_count[i] = 16'hFFFF;
            endcase
         b.elapsed_us = ($urandom_range(1) == 0) ? EUS_W'(1) : EUS_MAX;
      end else begin
         // standstill: counts repeat
         b.elapsed_us = EUS_W'($urandom_range(50000, 1));
      end
      if ($urandom_range(19) == 0) b.elapsed_us = '0;
      return b;
   endfunction

   task automatic check_field(string field, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d",
                  $time, field, $signed(want), $signed(got));
      end
   endtask

   // present one request beat, hold it until taken, then log its prediction
   task automatic send_beat(wheel_beat_type b, bit known, odometry_type known_result);
      odometry_type r;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_raw_count_0 = b.raw_count[0];
      req_raw_count_1 = b.raw_count[1];
      req_raw_count_2 = b.raw_count[2];
      req_raw_count_3 = b.raw_count[3];
      req_elapsed_us  = b.elapsed_us;
      do @(posedge clock); while (!req_ready);
      advance_odometry(b, r);
      pending_odometry.push_back(known ? known_result : r);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DPC_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIST_PER_COUNT: meters_per_count = data;
         CSR_TURN_GAIN:      turn_gain_q = data[TG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_odometry.size() != 0) @(posedge clock);
   endtask

   // result side backpressure
   always @(negedge clock) begin
      rsp_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   // result checker
   always @(posedge clock) begin : result_check
      odometry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_odometry.size() == 0) begin
            mismatch_count++;
            $display("%0t: result beat with nothing expected, pos_x %0d", $time, rsp_pos_x);
         end else begin
            want = pending_odometry.pop_front();
            check_field("pos_x", want.pos_x, rsp_pos_x);
            check_field("pos_y", want.pos_y, rsp_pos_y);
            check_field("heading", want.heading, rsp_heading);
            check_field("vel_x", want.vel_x, rsp_vel_x);
            check_field("vel_y", want.vel_y, rsp_vel_y);
            check_field("vel_turn", want.vel_turn, rsp_vel_turn);
         end
      end
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wheel_beat_type   prev;
      logic [DPC_W-1:0] cfg_dpc;
      logic [TG_W-1:0]  cfg_tg;

      meters_per_count = DPC_RESET;
      turn_gain_q      = TG_RESET;
      pos_x_sum        = '0;
      pos_y_sum        = '0;
      heading_sum      = '0;
      for (int i = 0; i < 4; i++) prev_tick[i] = '0;

      // directed rows: zero rows after reset have an obvious all-zero result
      directed_rows[0]  = mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, '0, 1'b1);
      directed_rows[1]  = mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd1000, 1'b1);
      directed_rows[2]  = mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, EUS_MAX, 1'b1);
      directed_rows[3]  = mk_row(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 24'd1, 1'b0);
      directed_rows[4]  = mk_row(16'h0000, 16'h0000, 16'h8000, 16'h0000, 24'd1, 1'b0);
      directed_rows[5]  = mk_row(16'h8000, 16'h8000, 16'h0000, 16'h0000, EUS_MAX, 1'b0);
      directed_rows[6]  = mk_row(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, '0, 1'b0);
      directed_rows[7]  = mk_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 24'd1, 1'b0);
      directed_rows[8]  = mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'd1, 1'b0);
      directed_rows[9]  = mk_row(16'hFF9C, 16'hFF9C, 16'h0064, 16'h0064, 24'd10000, 1'b0);
      directed_rows[10] = mk_row(16'h00C8, 16'hFF38, 16'h00C8, 16'hFF38, 24'd10000, 1'b0);
      directed_rows[11] = mk_row(16'h012C, 16'h012C, 16'h012C, 16'h012C, 24'd10000, 1'b0);
      directed_rows[12] = mk_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 24'h555555, 1'b0);
      directed_rows[13] = mk_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 24'hAAAAAA, 1'b0);
      directed_rows[14] = mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd2, 1'b0);
      directed_rows[15] = mk_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd3, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part with the reset configuration
      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].result);
      prev = directed_rows[DIRECTED_ROWS-1].beat;

      // random phases, each under its own configuration
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin cfg_dpc = '1; cfg_tg = '1; end
            1: begin cfg_dpc = '0; cfg_tg = '0; end
            2: begin cfg_dpc = '1; cfg_tg = '0; end
            3: begin cfg_dpc = '0; cfg_tg = '1; end
            BURST_PHASE: begin cfg_dpc = DPC_RESET; cfg_tg = TG_RESET; end
            6: begin cfg_dpc = DPC_W'($urandom_range(255, 1)); cfg_tg = TG_W'(1); end
            default: begin cfg_dpc = DPC_W'($urandom); cfg_tg = TG_W'($urandom); end
         endcase
         write_csr(CSR_SPARE_2, DPC_W'($urandom));
         write_csr(CSR_DIST_PER_COUNT, cfg_dpc);
         // upper write-data bits must be dropped for the 16-bit register
         write_csr(CSR_TURN_GAIN, {8'($urandom), cfg_tg});
         write_csr(CSR_SPARE_3, DPC_W'($urandom));
         no_idle = (phase == BURST_PHASE);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            prev = next_beat(prev);
            send_beat(prev, 1'b0, '0);
         end
         no_idle = 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
